>>> hdl/vpdab_pkg.sv
package vpdab_pkg;

   // visual class codes
   localparam logic [1:0] CLASS_INDEXED = 2'd0;
   localparam logic [1:0] CLASS_DIRECT  = 2'd1;
   localparam logic [1:0] CLASS_TRUE    = 2'd2;

   // request operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   // register indexes
   localparam logic [2:0] REG_VISUAL_CLASS = 3'd0;
   localparam logic [2:0] REG_WIDE_PIXEL   = 3'd1;
   localparam logic [2:0] REG_RED_SHIFT    = 3'd2;
   localparam logic [2:0] REG_RED_PREC     = 3'd3;
   localparam logic [2:0] REG_GREEN_SHIFT  = 3'd4;
   localparam logic [2:0] REG_GREEN_PREC   = 3'd5;
   localparam logic [2:0] REG_BLUE_SHIFT   = 3'd6;
   localparam logic [2:0] REG_BLUE_PREC    = 3'd7;

   // register reset values
   localparam logic [1:0] RST_VISUAL_CLASS = CLASS_TRUE;
   localparam logic       RST_WIDE_PIXEL   = 1'b1;
   localparam logic [4:0] RST_RED_SHIFT    = 5'd16;
   localparam logic [4:0] RST_GREEN_SHIFT  = 5'd8;
   localparam logic [4:0] RST_BLUE_SHIFT   = 5'd0;
   localparam logic [3:0] RST_PREC         = 4'd8;

   // channel numbering
   localparam int CHAN_RED   = 0;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 2;
   localparam int NUM_CHAN   = 3;

   typedef logic [NUM_CHAN-1:0][7:0] chan_byte_type;

   // precision above eight counts as eight
   function automatic logic [3:0] eff_prec(input logic [3:0] prec);
      return (prec > 4'd8) ? 4'd8 : prec;
   endfunction

   // masked channel field of a raw pixel
   function automatic logic [7:0] chan_field(input logic [31:0] pix,
                                             input logic [4:0]  shift,
                                             input logic [3:0]  prec);
      logic [31:0] shifted;
      logic [8:0]  mask;
      shifted = pix >> shift;
      mask    = (9'd1 << eff_prec(prec)) - 9'd1;
      return shifted[7:0] & mask[7:0];
   endfunction

   // left-align a narrow field to eight bits
   function automatic logic [7:0] left_align(input logic [7:0] field,
                                             input logic [3:0] prec);
      logic [3:0] amount;
      amount = 4'd8 - eff_prec(prec);
      return field << amount;
   endfunction

endpackage

>>> hdl/visual_pixel_decode_alpha_blend.sv
// a blend request passes stage one and then the output register to rsp_valid
// throughput: one request per cycle unless req_stall; the color table banks
//    take one read and one write per cycle; a load writes in its accept cycle
// reset: registers return to true color, 24-bit layout 16/8/0, precision 8;
//    per-entry valid bits clear at once so the whole table reads as zero
module visual_pixel_decode_alpha_blend #(
   parameter int MAP_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_dest_pixel,
   input  logic [7:0]  req_map_index,
   input  logic [7:0]  req_map_red,
   input  logic [7:0]  req_map_green,
   input  logic [7:0]  req_map_blue,
   input  logic [7:0]  req_src_red,
   input  logic [7:0]  req_src_green,
   input  logic [7:0]  req_src_blue,
   input  logic [7:0]  req_alpha,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (MAP_ENTRIES > 2) ? $clog2(MAP_ENTRIES) : 1;
   localparam int NC = vpdab_pkg::NUM_CHAN;

   // configuration registers
   logic [1:0]         class_ff;
   logic               wide_ff;
   logic [NC-1:0][4:0] shift_ff;
   logic [NC-1:0][3:0] prec_ff;
   logic               csr_wr;

   // color table banks, one per channel, and entry valid bits
   logic [7:0]             mem_red_ff   [MAP_ENTRIES];
   logic [7:0]             mem_green_ff [MAP_ENTRIES];
   logic [7:0]             mem_blue_ff  [MAP_ENTRIES];
   logic [MAP_ENTRIES-1:0] map_valid_ff;

   // request decode
   logic                   req_take;
   logic                   load_en;
   logic                   load_in_range;
   logic [AW-1:0]          load_addr;
   logic                   pix_in_range;
   logic                   use_map;
   vpdab_pkg::chan_byte_type field;
   vpdab_pkg::chan_byte_type tc_in;
   vpdab_pkg::chan_byte_type src_in;
   logic [NC-1:0][AW-1:0]  rd_addr;
   logic [NC-1:0]          in_range;

   // stage one
   logic                     s1_en;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic                     use_map_ff;
   logic [NC-1:0]            hit_ff;
   vpdab_pkg::chan_byte_type tc_ff;
   vpdab_pkg::chan_byte_type src_ff;
   vpdab_pkg::chan_byte_type rd_ff;
   logic [7:0]               alpha_ff;

   // blend and output register
   logic                     out_free;
   logic                     rsp_valid_ff;
   vpdab_pkg::chan_byte_type dec;
   vpdab_pkg::chan_byte_type blend_in;
   vpdab_pkg::chan_byte_type out_ff;
   logic [NC-1:0][15:0]      sum;
   logic [7:0]               inv_alpha;

   // register writes
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= vpdab_pkg::RST_VISUAL_CLASS;
         wide_ff  <= vpdab_pkg::RST_WIDE_PIXEL;
         shift_ff[vpdab_pkg::CHAN_RED]   <= vpdab_pkg::RST_RED_SHIFT;
         shift_ff[vpdab_pkg::CHAN_GREEN] <= vpdab_pkg::RST_GREEN_SHIFT;
         shift_ff[vpdab_pkg::CHAN_BLUE]  <= vpdab_pkg::RST_BLUE_SHIFT;
         prec_ff[vpdab_pkg::CHAN_RED]    <= vpdab_pkg::RST_PREC;
         prec_ff[vpdab_pkg::CHAN_GREEN]  <= vpdab_pkg::RST_PREC;
         prec_ff[vpdab_pkg::CHAN_BLUE]   <= vpdab_pkg::RST_PREC;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            vpdab_pkg::REG_VISUAL_CLASS: class_ff <= csr_pwdata[1:0];
            vpdab_pkg::REG_WIDE_PIXEL:   wide_ff  <= csr_pwdata[0];
            vpdab_pkg::REG_RED_SHIFT:    shift_ff[vpdab_pkg::CHAN_RED]   <= csr_pwdata[4:0];
            vpdab_pkg::REG_RED_PREC:     prec_ff[vpdab_pkg::CHAN_RED]    <= csr_pwdata[3:0];
            vpdab_pkg::REG_GREEN_SHIFT:  shift_ff[vpdab_pkg::CHAN_GREEN] <= csr_pwdata[4:0];
            vpdab_pkg::REG_GREEN_PREC:   prec_ff[vpdab_pkg::CHAN_GREEN]  <= csr_pwdata[3:0];
            vpdab_pkg::REG_BLUE_SHIFT:   shift_ff[vpdab_pkg::CHAN_BLUE]  <= csr_pwdata[4:0];
            vpdab_pkg::REG_BLUE_PREC:    prec_ff[vpdab_pkg::CHAN_BLUE]   <= csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // register reads
   always_comb begin
      csr_prdata = 32'd0;
      case (csr_paddr[4:2])
         vpdab_pkg::REG_VISUAL_CLASS: csr_prdata = 32'(class_ff);
         vpdab_pkg::REG_WIDE_PIXEL:   csr_prdata = 32'(wide_ff);
         vpdab_pkg::REG_RED_SHIFT:    csr_prdata = 32'(shift_ff[vpdab_pkg::CHAN_RED]);
         vpdab_pkg::REG_RED_PREC:     csr_prdata = 32'(prec_ff[vpdab_pkg::CHAN_RED]);
         vpdab_pkg::REG_GREEN_SHIFT:  csr_prdata = 32'(shift_ff[vpdab_pkg::CHAN_GREEN]);
         vpdab_pkg::REG_GREEN_PREC:   csr_prdata = 32'(prec_ff[vpdab_pkg::CHAN_GREEN]);
         vpdab_pkg::REG_BLUE_SHIFT:   csr_prdata = 32'(shift_ff[vpdab_pkg::CHAN_BLUE]);
         vpdab_pkg::REG_BLUE_PREC:    csr_prdata = 32'(prec_ff[vpdab_pkg::CHAN_BLUE]);
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // flow control: stage one holds only while the output register is blocked
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !out_free;
   assign s1_en       = !req_stall;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_valid && (req_op == vpdab_pkg::OP_BLEND);

   // table load
   assign load_in_range = 9'(req_map_index) < 9'(MAP_ENTRIES);
   assign load_addr     = req_map_index[AW-1:0];
   assign load_en       = req_take && (req_op == vpdab_pkg::OP_LOAD) && load_in_range;

   // pixel field extraction and table addresses
   assign pix_in_range = 33'(req_dest_pixel) < 33'(MAP_ENTRIES);
   assign use_map      = (class_ff == vpdab_pkg::CLASS_INDEXED) ||
                         (class_ff == vpdab_pkg::CLASS_DIRECT);
   assign src_in[vpdab_pkg::CHAN_RED]   = req_src_red;
   assign src_in[vpdab_pkg::CHAN_GREEN] = req_src_green;
   assign src_in[vpdab_pkg::CHAN_BLUE]  = req_src_blue;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         field[c] = vpdab_pkg::chan_field(req_dest_pixel, shift_ff[c], prec_ff[c]);
         tc_in[c] = wide_ff ? field[c] : vpdab_pkg::left_align(field[c], prec_ff[c]);
         if (class_ff == vpdab_pkg::CLASS_INDEXED) begin
            rd_addr[c]  = req_dest_pixel[AW-1:0];
            in_range[c] = pix_in_range;
         end else begin
            rd_addr[c]  = field[c][AW-1:0];
            in_range[c] = 9'(field[c]) < 9'(MAP_ENTRIES);
         end
      end
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
      end else if (load_en) begin
         map_valid_ff[load_addr] <= 1'b1;
      end
   end

   // color table banks: write on load, registered read on stage advance
   always_ff @(posedge clock) begin
      if (load_en) begin
         mem_red_ff[load_addr]   <= req_map_red;
         mem_green_ff[load_addr] <= req_map_green;
         mem_blue_ff[load_addr]  <= req_map_blue;
      end
      if (s1_en) begin
         rd_ff[vpdab_pkg::CHAN_RED]   <= mem_red_ff[rd_addr[vpdab_pkg::CHAN_RED]];
         rd_ff[vpdab_pkg::CHAN_GREEN] <= mem_green_ff[rd_addr[vpdab_pkg::CHAN_GREEN]];
         rd_ff[vpdab_pkg::CHAN_BLUE]  <= mem_blue_ff[rd_addr[vpdab_pkg::CHAN_BLUE]];
      end
   end

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (s1_en) begin
         use_map_ff <= use_map;
         tc_ff      <= tc_in;
         src_ff     <= src_in;
         alpha_ff   <= req_alpha;
         for (int c = 0; c < NC; c++) begin
            hit_ff[c] <= in_range[c] && map_valid_ff[rd_addr[c]];
         end
      end
   end

   // decoded destination and blend
   assign inv_alpha = 8'd255 - alpha_ff;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         if (use_map_ff) begin
            dec[c] = hit_ff[c] ? rd_ff[c] : 8'd0;
         end else begin
            dec[c] = tc_ff[c];
         end
         sum[c]      = 16'(dec[c]) * 16'(inv_alpha) + 16'(src_ff[c]) * 16'(alpha_ff);
         blend_in[c] = sum[c][15:8];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_ff <= blend_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = out_ff[vpdab_pkg::CHAN_RED];
   assign rsp_out_green = out_ff[vpdab_pkg::CHAN_GREEN];
   assign rsp_out_blue  = out_ff[vpdab_pkg::CHAN_BLUE];

`ifndef SYNTHESIS
   // an accepted blend request reaches stage one
   a_blend_enters: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_op == vpdab_pkg::OP_BLEND)) |=> s1_valid_ff)
      else $error("accepted blend request missing from stage one");

   // a loaded entry is marked valid
   a_load_marks: assert property (@(posedge clock) disable iff (reset)
      load_en |=> map_valid_ff[$past(load_addr)])
      else $error("loaded entry not marked valid");

   // stage one holds its request while the output is blocked
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=>
         (s1_valid_ff && (tc_ff === $past(tc_ff)) && (rd_ff === $past(rd_ff))))
      else $error("stage one lost a request under stall");

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response valid after reset");
`endif

endmodule

>>> tb/tb_visual_pixel_decode_alpha_blend.sv
`default_nettype none

module tb_visual_pixel_decode_alpha_blend;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAP_DEPTH    = 256;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          PRINT_LIMIT  = 40;
   // class code 3 has no name in the package, the block treats it as true color
   localparam logic [1:0]  CLASS_UNUSED = 2'd3;

   typedef struct packed {
      logic        op;
      logic [31:0] pix;
      logic [7:0]  map_idx;
      logic [7:0]  map_red;
      logic [7:0]  map_green;
      logic [7:0]  map_blue;
      logic [7:0]  src_red;
      logic [7:0]  src_green;
      logic [7:0]  src_blue;
      logic [7:0]  alpha;
   } pixel_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   wire         req_stall;
   logic        req_op = vpdab_pkg::OP_BLEND;
   logic [31:0] req_dest_pixel = '0;
   logic [7:0]  req_map_index = '0;
   logic [7:0]  req_map_red = '0;
   logic [7:0]  req_map_green = '0;
   logic [7:0]  req_map_blue = '0;
   logic [7:0]  req_src_red = '0;
   logic [7:0]  req_src_green = '0;
   logic [7:0]  req_src_blue = '0;
   logic [7:0]  req_alpha = '0;

   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [7:0]  rsp_out_red;
   wire  [7:0]  rsp_out_green;
   wire  [7:0]  rsp_out_blue;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   // predictor state: color table and register copies
   logic [23:0]   colour_table [MAP_DEPTH];
   logic [1:0]    cfg_class;
   logic          cfg_wide;
   logic [4:0]    cfg_shift [vpdab_pkg::NUM_CHAN];
   logic [3:0]    cfg_prec [vpdab_pkg::NUM_CHAN];

   pixel_req_type            pending_q [$];
   vpdab_pkg::chan_byte_type blend_expect_q [$];
   pixel_req_type            cur_req;
   vpdab_pkg::chan_byte_type rsp_got;
   vpdab_pkg::chan_byte_type rsp_want;
   string         chan_name [vpdab_pkg::NUM_CHAN] = '{"red", "green", "blue"};

   int unsigned   send_idle_pct = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   pushed_cnt = 0;
   int unsigned   accepted_cnt = 0;
   int unsigned   n_load = 0;
   int unsigned   n_blend = 0;
   int unsigned   n_setting = 0;
   int unsigned   err_cnt = 0;
   int unsigned   cycle_cnt = 0;

   visual_pixel_decode_alpha_blend dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_dest_pixel (req_dest_pixel),
      .req_map_index  (req_map_index),
      .req_map_red    (req_map_red),
      .req_map_green  (req_map_green),
      .req_map_blue   (req_map_blue),
      .req_src_red    (req_src_red),
      .req_src_green  (req_src_green),
      .req_src_blue   (req_src_blue),
      .req_alpha      (req_alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (err_cnt < PRINT_LIMIT) begin
         $display("error at cycle %0d: %s", cycle_cnt, msg);
      end
      err_cnt++;
   endtask

   // decoded destination channel blended with the source color
   function automatic vpdab_pkg::chan_byte_type predict_blend(input pixel_req_type r);
      vpdab_pkg::chan_byte_type res;
      vpdab_pkg::chan_byte_type src_rgb;
      logic [3:0]    p;
      logic [7:0]    fld;
      logic [7:0]    dst;
      logic [23:0]   entry;
      logic [15:0]   widened;
      logic [31:0]   mix;
      src_rgb[vpdab_pkg::CHAN_RED]   = r.src_red;
      src_rgb[vpdab_pkg::CHAN_GREEN] = r.src_green;
      src_rgb[vpdab_pkg::CHAN_BLUE]  = r.src_blue;
      for (int c = 0; c < vpdab_pkg::NUM_CHAN; c++) begin
         p   = (cfg_prec[c] > 4'd8) ? 4'd8 : cfg_prec[c];
         fld = 8'((r.pix >> cfg_shift[c]) & ((32'd1 << p) - 32'd1));
         case (cfg_class)
            vpdab_pkg::CLASS_INDEXED: begin
               entry = (r.pix < MAP_DEPTH) ? colour_table[r.pix[7:0]] : 24'd0;
               dst   = entry[23-8*c -: 8];
            end
            vpdab_pkg::CLASS_DIRECT: begin
               entry = colour_table[fld];
               dst   = entry[23-8*c -: 8];
            end
            default: begin
               // true color, narrow pixels get their fields left-aligned
               widened = {8'd0, fld} << (4'd8 - p);
               dst     = cfg_wide ? fld : widened[7:0];
            end
         endcase
         mix = (32'(dst) * (32'd255 - 32'(r.alpha)) + 32'(src_rgb[c]) * 32'(r.alpha)) >> 8;
         res[c] = (mix > 32'd255) ? 8'd255 : mix[7:0];
      end
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            if (cur_req.op == vpdab_pkg::OP_LOAD) begin
               colour_table[cur_req.map_idx] = {cur_req.map_red, cur_req.map_green,
                                                cur_req.map_blue};
               n_load++;
            end else begin
               blend_expect_q.push_back(predict_blend(cur_req));
               n_blend++;
            end
            accepted_cnt++;
         end
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_req = pending_q.pop_front();
            req_valid      <= 1'b1;
            req_op         <= cur_req.op;
            req_dest_pixel <= cur_req.pix;
            req_map_index  <= cur_req.map_idx;
            req_map_red    <= cur_req.map_red;
            req_map_green  <= cur_req.map_green;
            req_map_blue   <= cur_req.map_blue;
            req_src_red    <= cur_req.src_red;
            req_src_green  <= cur_req.src_green;
            req_src_blue   <= cur_req.src_blue;
            req_alpha      <= cur_req.alpha;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result monitor and random stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_got[vpdab_pkg::CHAN_RED]   = rsp_out_red;
            rsp_got[vpdab_pkg::CHAN_GREEN] = rsp_out_green;
            rsp_got[vpdab_pkg::CHAN_BLUE]  = rsp_out_blue;
            if (blend_expect_q.size() == 0) begin
               report_error($sformatf("result %02h %02h %02h with no request pending",
                                      rsp_out_red, rsp_out_green, rsp_out_blue));
            end else begin
               rsp_want = blend_expect_q.pop_front();
               for (int c = 0; c < vpdab_pkg::NUM_CHAN; c++) begin
                  if (rsp_got[c] !== rsp_want[c]) begin
                     report_error($sformatf("%s got %02h want %02h", chan_name[c],
                                            rsp_got[c], rsp_want[c]));
                  end
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // register write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] reg_idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_idx)
         vpdab_pkg::REG_VISUAL_CLASS: cfg_class = val[1:0];
         vpdab_pkg::REG_WIDE_PIXEL:   cfg_wide = val[0];
         vpdab_pkg::REG_RED_SHIFT:    cfg_shift[vpdab_pkg::CHAN_RED] = val[4:0];
         vpdab_pkg::REG_RED_PREC:     cfg_prec[vpdab_pkg::CHAN_RED] = val[3:0];
         vpdab_pkg::REG_GREEN_SHIFT:  cfg_shift[vpdab_pkg::CHAN_GREEN] = val[4:0];
         vpdab_pkg::REG_GREEN_PREC:   cfg_prec[vpdab_pkg::CHAN_GREEN] = val[3:0];
         vpdab_pkg::REG_BLUE_SHIFT:   cfg_shift[vpdab_pkg::CHAN_BLUE] = val[4:0];
         vpdab_pkg::REG_BLUE_PREC:    cfg_prec[vpdab_pkg::CHAN_BLUE] = val[3:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [1:0] cls, input logic wide,
                                input logic [4:0] rs, input logic [3:0] rp,
                                input logic [4:0] gs, input logic [3:0] gp,
                                input logic [4:0] bs, input logic [3:0] bp);
      csr_write(vpdab_pkg::REG_VISUAL_CLASS, 32'(cls));
      csr_write(vpdab_pkg::REG_WIDE_PIXEL, 32'(wide));
      csr_write(vpdab_pkg::REG_RED_SHIFT, 32'(rs));
      csr_write(vpdab_pkg::REG_RED_PREC, 32'(rp));
      csr_write(vpdab_pkg::REG_GREEN_SHIFT, 32'(gs));
      csr_write(vpdab_pkg::REG_GREEN_PREC, 32'(gp));
      csr_write(vpdab_pkg::REG_BLUE_SHIFT, 32'(bs));
      csr_write(vpdab_pkg::REG_BLUE_PREC, 32'(bp));
      n_setting++;
   endtask

   // sender pauses until every request is taken and every result is back
   task automatic wait_drain();
      while (accepted_cnt != pushed_cnt || blend_expect_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_req(input pixel_req_type r);
      pending_q.push_back(r);
      pushed_cnt++;
   endtask

   task automatic push_load(input logic [7:0] idx, input logic [7:0] red,
                            input logic [7:0] green, input logic [7:0] blue);
      pixel_req_type r;
      r = '0;
      r.op        = vpdab_pkg::OP_LOAD;
      r.map_idx   = idx;
      r.map_red   = red;
      r.map_green = green;
      r.map_blue  = blue;
      push_req(r);
   endtask

   task automatic push_blend(input logic [31:0] pix, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue,
                             input logic [7:0] alpha);
      pixel_req_type r;
      r = '0;
      r.op        = vpdab_pkg::OP_BLEND;
      r.pix       = pix;
      r.src_red   = red;
      r.src_green = green;
      r.src_blue  = blue;
      r.alpha     = alpha;
      push_req(r);
   endtask

   // random mix of loads and blends, unused fields carry noise
   task automatic push_random(input int count);
      pixel_req_type r;
      repeat (count) begin
         r.op        = ($urandom_range(99) < 30) ? vpdab_pkg::OP_LOAD : vpdab_pkg::OP_BLEND;
         r.pix       = $urandom();
         r.map_idx   = 8'($urandom_range(255));
         r.map_red   = 8'($urandom_range(255));
         r.map_green = 8'($urandom_range(255));
         r.map_blue  = 8'($urandom_range(255));
         r.src_red   = 8'($urandom_range(255));
         r.src_green = 8'($urandom_range(255));
         r.src_blue  = 8'($urandom_range(255));
         r.alpha     = 8'($urandom_range(255));
         // indexed pixels mostly land inside the table
         if (cfg_class == vpdab_pkg::CLASS_INDEXED && $urandom_range(99) < 80) begin
            r.pix = $urandom_range(MAP_DEPTH - 1);
         end
         case ($urandom_range(7))
            0: r.alpha = 8'd0;
            1: r.alpha = 8'd255;
            default: ;
         endcase
         push_req(r);
      end
   endtask

   initial begin
      // predictor reset state
      foreach (colour_table[i]) colour_table[i] = 24'd0;
      cfg_class                       = vpdab_pkg::RST_VISUAL_CLASS;
      cfg_wide                        = vpdab_pkg::RST_WIDE_PIXEL;
      cfg_shift[vpdab_pkg::CHAN_RED]   = vpdab_pkg::RST_RED_SHIFT;
      cfg_shift[vpdab_pkg::CHAN_GREEN] = vpdab_pkg::RST_GREEN_SHIFT;
      cfg_shift[vpdab_pkg::CHAN_BLUE]  = vpdab_pkg::RST_BLUE_SHIFT;
      foreach (cfg_prec[i]) cfg_prec[i] = vpdab_pkg::RST_PREC;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset layout, true color 24-bit: sender light idle, receiver heavy stall
      send_idle_pct  = 25;
      recv_stall_pct = 70;
      push_load(8'h00, 8'hFF, 8'h00, 8'hFF);
      push_load(8'hFF, 8'h00, 8'hFF, 8'h00);
      push_load(8'h01, 8'h12, 8'h34, 8'h56);
      push_load(8'h80, 8'hFF, 8'hFF, 8'hFF);
      push_blend(32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'd0);
      push_blend(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'd255);
      push_blend(32'h00FF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);
      push_blend(32'h0012_3456, 8'h80, 8'h7F, 8'h01, 8'd128);
      push_blend(32'hFF00_FF00, 8'hFF, 8'h00, 8'hFF, 8'd1);
      push_random(80);
      wait_drain();

      // indexed class, including pixels past the end of the table
      apply_setting(vpdab_pkg::CLASS_INDEXED, 1'b1, 5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8);
      push_blend(32'd0, 8'h00, 8'h00, 8'h00, 8'd0);
      push_blend(32'd1, 8'h00, 8'h00, 8'h00, 8'd0);
      push_blend(32'd255, 8'h00, 8'h00, 8'h00, 8'd0);
      push_blend(32'd256, 8'hFF, 8'hFF, 8'hFF, 8'd0);
      push_blend(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'd64);
      // load then read the same entry back to back
      push_load(8'h02, 8'hA5, 8'h5A, 8'hC3);
      push_blend(32'd2, 8'h00, 8'h00, 8'h00, 8'd0);
      push_random(80);
      wait_drain();

      // direct color with a one-bit field at bit 31: heavy idle, light stall
      send_idle_pct  = 70;
      recv_stall_pct = 25;
      apply_setting(vpdab_pkg::CLASS_DIRECT, 1'b0, 5'd24, 4'd8, 5'd3, 4'd5, 5'd31, 4'd1);
      push_random(80);
      wait_drain();

      // 16-bit 5/6/5 layout, left-aligned fields
      apply_setting(vpdab_pkg::CLASS_TRUE, 1'b0, 5'd11, 4'd5, 5'd5, 4'd6, 5'd0, 4'd5);
      push_random(80);
      wait_drain();

      // unused class code, empty field, oversized fields, field past bit 31
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_setting(CLASS_UNUSED, 1'b0, 5'd31, 4'd0, 5'd28, 4'd15, 5'd4, 4'd9);
      push_blend(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'd0);
      push_blend(32'hF000_0FF0, 8'hFF, 8'hFF, 8'hFF, 8'd200);
      push_random(80);
      wait_drain();

      // random layouts across the full register ranges
      repeat (3) begin
         apply_setting(2'($urandom_range(3)), 1'($urandom_range(1)),
                       5'($urandom_range(31)), 4'($urandom_range(15)),
                       5'($urandom_range(31)), 4'($urandom_range(15)),
                       5'($urandom_range(31)), 4'($urandom_range(15)));
         push_random(40);
         wait_drain();
      end

      $display("covered %0d color table loads and %0d blended pixels", n_load, n_blend);
      $display("over %0d register layouts with mixed idle and stall patterns", n_setting);
      if (err_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
